/* rtl/ssso_pkg.sv */
// Package for the stereo saw swarm oscillator unit.
// Holds the function codes and the fixed payload widths.
// No dependencies.
package ssso_pkg;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 4;
    localparam int INC_W   = 32;
    localparam int GAIN_W  = 12;
    localparam int GATE_W  = 16;
    localparam int SMPL_W  = 16;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_TICK    = 2'd0;
    localparam func_t FUNC_SET_SAW = 2'd1;
    localparam func_t FUNC_SET_SUB = 2'd2;

    typedef logic signed [SMPL_W-1:0] sample_t;

endpackage

/* rtl/ssso_if.sv */
// Channel interfaces for the stereo saw swarm oscillator unit.
// ssso_cmd_if carries command transactions, ssso_smp_if sample transactions.
// Depends on ssso_pkg.
interface ssso_cmd_if
    import ssso_pkg::*;
;
    logic                valid;
    logic                ready;
    func_t               func;
    logic [IDX_W-1:0]    osc_index;
    logic [INC_W-1:0]    increment;
    logic [GAIN_W-1:0]   saw_gain;
    logic [GAIN_W-1:0]   sub_gain;
    logic [GATE_W-1:0]   gate_value;

    modport source (
        output valid, func, osc_index, increment, saw_gain, sub_gain, gate_value,
        input  ready
    );
    modport sink (
        input  valid, func, osc_index, increment, saw_gain, sub_gain, gate_value,
        output ready
    );
endinterface

interface ssso_smp_if
    import ssso_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;

    modport source (
        output valid, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample,
        output ready
    );
endinterface

/* rtl/stereo_saw_swarm_oscillator_unit.sv */
// Stereo saw swarm oscillator unit: NUM_OSC saw phase accumulators and a
// triangle sub oscillator mixed to a stereo pair, one sample per tick.
// Depends on ssso_pkg and the interfaces in ssso_if.sv.
//
// Usage:
//   cmd    : command transactions. func selects a sample tick, a saw
//            increment write (osc_index, increment) or a sub increment write.
//            Writes produce no sample.
//   result : one left/right sample transaction per tick.
// Timing:
//   A tick walks the oscillators one per cycle through the phase and
//   increment memories (registered read), then one shared multiplier runs
//   six products in turn. cmd is not ready while a tick is in progress,
//   so no new command is taken until the tick has finished.
// Reset: phases and increments read as zero (per-entry valid flags), no
//   sample pending.
// Stall: the result register holds a sample until taken; commands are
//   accepted meanwhile, and a following tick waits at its end for the slot.
module stereo_saw_swarm_oscillator_unit
    import ssso_pkg::*;
#(
    parameter int NUM_OSC = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    ssso_cmd_if.sink        cmd,
    ssso_smp_if.source      result
);

    localparam int OW    = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int ACC_W = SMPL_W + $clog2(NUM_OSC);
    localparam int MA    = ACC_W + 2;
    localparam int MB    = GATE_W + 1;
    localparam int PW    = MA + MB;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_ML    = 4'd3;
    localparam logic [3:0] S_MR    = 4'd4;
    localparam logic [3:0] S_MS    = 4'd5;
    localparam logic [3:0] S_MG    = 4'd6;
    localparam logic [3:0] S_MOL   = 4'd7;
    localparam logic [3:0] S_MOR   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [OW-1:0]           cnt_reg;
    logic                    rd_v_reg;
    logic [OW-1:0]           rd_idx_reg;
    logic [INC_W-1:0]        ph_rd_reg, inc_rd_reg;
    logic                    ph_vq_reg, inc_vq_reg;
    logic [NUM_OSC-1:0]      ph_valid_reg, inc_valid_reg;
    logic [INC_W-1:0]        phase_mem [NUM_OSC];
    logic [INC_W-1:0]        inc_mem [NUM_OSC];
    logic [INC_W-1:0]        sub_phase_reg, sub_inc_reg;
    logic [GAIN_W-1:0]       saw_gain_reg, sub_gain_reg;
    logic [GATE_W-1:0]       gate_reg, gmul_reg;
    logic signed [ACC_W-1:0] left_acc_reg, right_acc_reg;
    logic signed [MA-1:0]    left_mix_reg, right_mix_reg;
    logic signed [PW-1:0]    prod_reg;
    sample_t                 left_sat_reg;
    logic                    out_valid_reg;
    sample_t                 out_left_reg, out_right_reg;

    logic                    cmd_fire, tick_fire, saw_wr, sub_wr;
    logic [OW-1:0]           wr_idx;
    logic [INC_W-1:0]        phase_new;
    logic signed [SMPL_W-1:0] saw_val;
    logic [14:0]             fold;
    logic signed [SMPL_W-1:0] sub_val;
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [MA-1:0]    prod_shr12;
    logic                    out_load;

    function automatic sample_t sat_q16(input logic signed [PW-1:0] p);
        logic [PW-32:0] upper;
        begin
            upper = p[PW-1:31];
            if ((&upper) || !(|upper))
            begin
                sat_q16 = p[31:16];
            end
            else if (p[PW-1])
            begin
                sat_q16 = 16'sh8000;
            end
            else
            begin
                sat_q16 = 16'sh7fff;
            end
        end
    endfunction

    assign cmd.ready     = (state_reg == S_IDLE);
    assign cmd_fire      = cmd.valid && cmd.ready;
    assign tick_fire     = cmd_fire && (cmd.func == FUNC_TICK);
    assign wr_idx        = OW'(cmd.osc_index);
    assign saw_wr        = cmd_fire && (cmd.func == FUNC_SET_SAW)
                           && (32'(cmd.osc_index) < NUM_OSC);
    assign sub_wr        = cmd_fire && (cmd.func == FUNC_SET_SUB);

    assign phase_new     = (ph_vq_reg ? ph_rd_reg : '0) + (inc_vq_reg ? inc_rd_reg : '0);
    assign saw_val       = $signed({~phase_new[31], phase_new[30:16]});

    assign fold          = sub_phase_reg[31] ? ~sub_phase_reg[30:16] : sub_phase_reg[30:16];
    assign sub_val       = $signed({~fold[14], fold[13:0], 1'b0});

    assign prod_shr12    = $signed(prod_reg[MA+11:12]);
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ML:
            begin
                mul_a = MA'(left_acc_reg >>> 3);
                mul_b = MB'(saw_gain_reg);
            end
            S_MR:
            begin
                mul_a = MA'(right_acc_reg >>> 3);
                mul_b = MB'(saw_gain_reg);
            end
            S_MS:
            begin
                mul_a = MA'(sub_val);
                mul_b = MB'(sub_gain_reg);
            end
            S_MG:
            begin
                mul_a = MA'(gate_reg);
                mul_b = MB'(gate_reg);
            end
            S_MOL:
            begin
                mul_a = left_mix_reg;
                mul_b = MB'(prod_reg[31:16]);
            end
            S_MOR:
            begin
                mul_a = right_mix_reg;
                mul_b = MB'(gmul_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = tick_fire ? S_SWEEP : S_IDLE;
            S_SWEEP: state_next = (cnt_reg == OW'(NUM_OSC - 1)) ? S_DRAIN : S_SWEEP;
            S_DRAIN: state_next = S_ML;
            S_ML:    state_next = S_MR;
            S_MR:    state_next = S_MS;
            S_MS:    state_next = S_MG;
            S_MG:    state_next = S_MOL;
            S_MOL:   state_next = S_MOR;
            S_MOR:   state_next = S_OUT;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            ph_valid_reg  <= '0;
            inc_valid_reg <= '0;
            sub_phase_reg <= '0;
            sub_inc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == S_SWEEP);
            if (tick_fire)
            begin
                cnt_reg       <= '0;
                sub_phase_reg <= sub_phase_reg + sub_inc_reg;
            end
            else if (state_reg == S_SWEEP)
            begin
                cnt_reg <= cnt_reg + OW'(1);
            end
            if (sub_wr)
            begin
                sub_inc_reg <= cmd.increment;
            end
            if (saw_wr)
            begin
                inc_valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_v_reg)
            begin
                ph_valid_reg[rd_idx_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Phase and increment memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWEEP)
        begin
            ph_rd_reg  <= phase_mem[cnt_reg];
            inc_rd_reg <= inc_mem[cnt_reg];
            ph_vq_reg  <= ph_valid_reg[cnt_reg];
            inc_vq_reg <= inc_valid_reg[cnt_reg];
            rd_idx_reg <= cnt_reg;
        end
        if (rd_v_reg)
        begin
            phase_mem[rd_idx_reg] <= phase_new;
        end
        if (saw_wr)
        begin
            inc_mem[wr_idx] <= cmd.increment;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            saw_gain_reg  <= cmd.saw_gain;
            sub_gain_reg  <= cmd.sub_gain;
            gate_reg      <= cmd.gate_value;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end
        else if (rd_v_reg)
        begin
            if (rd_idx_reg[0])
            begin
                right_acc_reg <= right_acc_reg + ACC_W'(saw_val);
            end
            else
            begin
                left_acc_reg <= left_acc_reg + ACC_W'(saw_val);
            end
        end
        case (state_reg)
            S_ML:
            begin
                prod_reg <= mul_p;
            end
            S_MR:
            begin
                left_mix_reg <= prod_shr12;
                prod_reg     <= mul_p;
            end
            S_MS:
            begin
                right_mix_reg <= prod_shr12;
                prod_reg      <= mul_p;
            end
            S_MG:
            begin
                left_mix_reg  <= left_mix_reg + prod_shr12;
                right_mix_reg <= right_mix_reg + prod_shr12;
                prod_reg      <= mul_p;
            end
            S_MOL:
            begin
                gmul_reg <= prod_reg[31:16];
                prod_reg <= mul_p;
            end
            S_MOR:
            begin
                left_sat_reg <= sat_q16(prod_reg);
                prod_reg     <= mul_p;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (out_load)
        begin
            out_left_reg  <= left_sat_reg;
            out_right_reg <= sat_q16(prod_reg);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.left_sample  = out_left_reg;
    assign result.right_sample = out_right_reg;

endmodule

/* bench/ssso_mix_checker.sv */
`timescale 1ns / 1ps
// Checker for the stereo saw swarm oscillator unit: watches both channels,
// predicts each stereo sample from its own oscillator bank and compares.
// Depends on ssso_pkg and the interfaces in rtl/ssso_if.sv.
module ssso_mix_checker
    import ssso_pkg::*;
#(
    parameter int NUM_OSC = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    ssso_cmd_if     cmd,
    ssso_smp_if     smp,
    output int      error_count,
    output int      samples_owed
);

    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_t;

    logic [INC_W-1:0] saw_phase [NUM_OSC];
    logic [INC_W-1:0] saw_step [NUM_OSC];
    logic [INC_W-1:0] sub_phase;
    logic [INC_W-1:0] sub_step;

    stereo_t stereo_due_q [$];
    stereo_t owed;
    int      fails = 0;

    assign error_count = fails;

    function automatic sample_t clip16(longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return sample_t'(v);
    endfunction

    // Advances every phase, then mixes: saws split even/odd, sub folded.
    function automatic stereo_t next_stereo_sample(logic [GAIN_W-1:0] saw_lvl,
                                                   logic [GAIN_W-1:0] sub_lvl,
                                                   logic [GATE_W-1:0] gate);
        longint  acc_l;
        longint  acc_r;
        longint  saw;
        longint  fold;
        longint  sub_val;
        longint  gate_sq;
        stereo_t res;
        acc_l = 0;
        acc_r = 0;
        for (int i = 0; i < NUM_OSC; i++)
        begin
            saw_phase[i] = saw_phase[i] + saw_step[i];
            saw = longint'(saw_phase[i][31:16]) - 32768;
            if (i % 2 == 1)
            begin
                acc_r = acc_r + saw;
            end
            else
            begin
                acc_l = acc_l + saw;
            end
        end
        acc_l = ((acc_l >>> 3) * longint'(saw_lvl)) >>> 12;
        acc_r = ((acc_r >>> 3) * longint'(saw_lvl)) >>> 12;

        sub_phase = sub_phase + sub_step;
        fold = longint'(sub_phase[31:16]);
        if (fold >= 32768)
        begin
            fold = 65535 - fold;
        end
        sub_val = ((fold - 16384) * 2 * longint'(sub_lvl)) >>> 12;

        gate_sq = (longint'(gate) * longint'(gate)) >>> 16;
        acc_l = ((acc_l + sub_val) * gate_sq) >>> 16;
        acc_r = ((acc_r + sub_val) * gate_sq) >>> 16;
        res.left = clip16(acc_l);
        res.right = clip16(acc_r);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_OSC; k++)
            begin
                saw_phase[k] = '0;
                saw_step[k] = '0;
            end
            sub_phase = '0;
            sub_step = '0;
            stereo_due_q.delete();
            samples_owed <= 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
            begin
                if (stereo_due_q.size() == 0)
                begin
                    $error("unexpected sample transaction: left_sample %0d right_sample %0d",
                           smp.left_sample, smp.right_sample);
                    fails++;
                end
                else
                begin
                    owed = stereo_due_q.pop_front();
                    if (smp.left_sample !== owed.left)
                    begin
                        $error("left_sample: expected %0d, actual %0d",
                               owed.left, smp.left_sample);
                        fails++;
                    end
                    if (smp.right_sample !== owed.right)
                    begin
                        $error("right_sample: expected %0d, actual %0d",
                               owed.right, smp.right_sample);
                        fails++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.func)
                    FUNC_TICK:
                    begin
                        stereo_due_q.push_back(next_stereo_sample(cmd.saw_gain,
                                                                  cmd.sub_gain,
                                                                  cmd.gate_value));
                    end
                    FUNC_SET_SAW:
                    begin
                        if (cmd.osc_index < NUM_OSC)
                        begin
                            saw_step[cmd.osc_index] = cmd.increment;
                        end
                    end
                    FUNC_SET_SUB:
                    begin
                        sub_step = cmd.increment;
                    end
                    default:
                    begin
                    end
                endcase
            end
            samples_owed <= stereo_due_q.size();
        end
    end

endmodule

/* bench/stereo_saw_swarm_oscillator_unit_test.sv */
`timescale 1ns / 1ps
// Top of the stereo saw swarm oscillator unit bench: clock, reset, command
// stimulus with bursts and gaps, sample back-pressure and the verdict.
// Depends on ssso_pkg, rtl/ssso_if.sv, the unit and ssso_mix_checker.
module stereo_saw_swarm_oscillator_unit_test;
    import ssso_pkg::*;

    localparam int    NUM_OSC      = 16;
    localparam func_t FUNC_IGNORED = 2'd3;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    RANDOM_ITEMS = 1550;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_total;
    int   samples_owed;
    int   burst_left = 1;
    int   useful_sent = 0;
    int   item_no = 0;
    int   roll;
    int   rx_mode = 0;
    int   rx_left = 0;
    bit   long_hold_req = 1'b0;

    func_t             pick_func;
    logic [INC_W-1:0]  pick_inc;
    logic [GATE_W-1:0] pick_gate;

    ssso_cmd_if cmd_ch ();
    ssso_smp_if smp_ch ();

    stereo_saw_swarm_oscillator_unit #(
        .NUM_OSC (NUM_OSC)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (smp_ch)
    );

    ssso_mix_checker #(
        .NUM_OSC (NUM_OSC)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .smp          (smp_ch),
        .error_count  (mismatch_total),
        .samples_owed (samples_owed)
    );

    always #10 clk = ~clk;

    function automatic logic [GAIN_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // One command transaction, then the burst/gap bookkeeping.
    task automatic offer_cmd(input func_t             f,
                             input logic [IDX_W-1:0]  idx,
                             input logic [INC_W-1:0]  inc,
                             input logic [GAIN_W-1:0] saw_lvl,
                             input logic [GAIN_W-1:0] sub_lvl,
                             input logic [GATE_W-1:0] gate);
        int gap;
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.osc_index  <= idx;
        cmd_ch.increment  <= inc;
        cmd_ch.saw_gain   <= saw_lvl;
        cmd_ch.sub_gain   <= sub_lvl;
        cmd_ch.gate_value <= gate;
        do @(posedge clk); while (!cmd_ch.ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
                cmd_ch.func  <= func_t'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Sample side: changing stall modes, plus one long hold on request.
    initial
    begin
        smp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                smp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(20, 80);
                end
                rx_left--;
                case (rx_mode)
                    0: smp_ch.ready <= 1'b1;
                    1: smp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: smp_ch.ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("stereo_saw_swarm_oscillator_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_TICK;
        cmd_ch.osc_index  <= '0;
        cmd_ch.increment  <= '0;
        cmd_ch.saw_gain   <= '0;
        cmd_ch.sub_gain   <= '0;
        cmd_ch.gate_value <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all phases at zero: every saw at its minimum, deep negative clip
        offer_cmd(FUNC_TICK, '0, '0, 12'hFFF, 12'hFFF, 16'hFFFF);
        offer_cmd(FUNC_TICK, '1, '1, 12'h000, 12'h000, 16'hFFFF);
        offer_cmd(FUNC_TICK, '0, '0, 12'hFFF, 12'hFFF, 16'h0000);
        offer_cmd(FUNC_IGNORED, '1, '1, '1, '1, '1);
        // push every saw to its top, then positive clip
        for (int i = 0; i < NUM_OSC; i++)
        begin
            offer_cmd(FUNC_SET_SAW, IDX_W'(i), (i == 0) ? 32'hFFFF_FFFF : 32'hFFFF_0000,
                      '0, '0, '0);
        end
        offer_cmd(FUNC_SET_SUB, '0, 32'h8000_0000, '0, '0, '0);
        offer_cmd(FUNC_TICK, '0, '0, 12'hFFF, 12'hFFF, 16'hFFFF);
        // sub stepped back just below the fold, into the unfolded half
        offer_cmd(FUNC_SET_SUB, '0, 32'hFFFF_FFFF, '0, '0, '0);
        offer_cmd(FUNC_TICK, '0, '0, 12'h800, 12'hFFF, 16'h8000);
        offer_cmd(FUNC_TICK, '0, '0, 12'hFFF, 12'h000, 16'hFFFF);

        while (useful_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                pick_func = FUNC_TICK;
            else if (roll < 80)
                pick_func = FUNC_SET_SAW;
            else if (roll < 93)
                pick_func = FUNC_SET_SUB;
            else
                pick_func = FUNC_IGNORED;
            case ($urandom_range(0, 7))
                0: pick_inc = '0;
                1: pick_inc = '1;
                2: pick_inc = INC_W'($urandom_range(0, 65535));
                default: pick_inc = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
                pick_gate = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            else
                pick_gate = GATE_W'($urandom);
            offer_cmd(pick_func, IDX_W'($urandom), pick_inc, rand_level(), rand_level(),
                      pick_gate);
            if (pick_func != FUNC_IGNORED)
                useful_sent++;
            item_no++;
            if (item_no == 300)
                long_hold_req = 1'b1;
            if (item_no == 800)
            begin
                // drain fully before carrying on
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
                wait (samples_owed == 0);
            end
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait (samples_owed == 0);
        repeat (40) @(posedge clk);
        if (mismatch_total == 0)
            $display("stereo_saw_swarm_oscillator_unit_test: done, clean");
        else
            $display("stereo_saw_swarm_oscillator_unit_test: done, errors");
        $finish;
    end

endmodule

/* stereo_saw_swarm_oscillator_unit.f */
rtl/ssso_pkg.sv
rtl/ssso_if.sv
rtl/stereo_saw_swarm_oscillator_unit.sv
bench/ssso_mix_checker.sv
bench/stereo_saw_swarm_oscillator_unit_test.sv
